>>> rtl/ssd_pkg.sv
// Shared types and constants for the staggered stencil derivative core.
`default_nettype none

package ssd_pkg;

    // Word format of every field and of the result.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Product operands hold the widest stencil combination (5 extra bits).
    localparam int OP_W   = DATA_WIDTH + 5;
    localparam int PROD_W = 2 * OP_W;
    // Numerator width; arithmetic wraps modulo 2^128 beyond that.
    localparam int NUM_W  = (PROD_W + 1 > 128) ? 128 : PROD_W + 1;
    // Magnitude width handled by the divide-by-three and saturation stages.
    localparam int QW     = DATA_WIDTH + 1;
    localparam int SH_W   = $clog2(FRAC_BITS + 7);

    // Reciprocal of three: floor(2^RECIP_S / 3), exact to one unit below QW bits.
    localparam int RECIP_S = QW;
    localparam logic [QW:0] RECIP_TWO_S = (QW + 1)'(1) << RECIP_S;
    localparam logic [QW:0] RECIP_FULL  = RECIP_TWO_S / 3;
    localparam logic [DATA_WIDTH-1:0] RECIP_K = RECIP_FULL[DATA_WIDTH-1:0];

    // Right-shift amounts that undo the fixed-point and constant scaling.
    localparam logic [SH_W-1:0] SH_NONE = SH_W'(0);
    localparam logic [SH_W-1:0] SH_HALF = SH_W'(1);
    localparam logic [SH_W-1:0] SH_C4   = SH_W'(3);
    localparam logic [SH_W-1:0] SH_PROD = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_U2   = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_VC2  = SH_W'(FRAC_BITS + 2);
    localparam logic [SH_W-1:0] SH_VC4  = SH_W'(FRAC_BITS + 6);

    typedef enum logic [3:0] {
        M_DDX_C2   = 4'd0,
        M_DDX_C4   = 4'd1,
        M_D2DX2_C2 = 4'd2,
        M_VDDX_U1  = 4'd3,
        M_VDDX_U2  = 4'd4,
        M_VDDX_C2  = 4'd5,
        M_VDDX_C4  = 4'd6,
        M_FDDX_U1  = 4'd7,
        M_FDDX_U2  = 4'd8
    } t_method;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] f_mm;
        logic signed [DATA_WIDTH-1:0] f_m;
        logic signed [DATA_WIDTH-1:0] f_c;
        logic signed [DATA_WIDTH-1:0] f_p;
        logic signed [DATA_WIDTH-1:0] f_pp;
        logic signed [DATA_WIDTH-1:0] v_mm;
        logic signed [DATA_WIDTH-1:0] v_m;
        logic signed [DATA_WIDTH-1:0] v_p;
        logic signed [DATA_WIDTH-1:0] v_pp;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] deriv_out;
        logic                         saturated;
    } t_out;

    // Per-item scaling that travels alongside the numerator.
    typedef struct packed {
        logic [SH_W-1:0] sh;
        logic            div3;
    } t_ctl;

endpackage

`default_nettype wire

>>> rtl/ssd_prod.sv
// Two-stage signed multiplier that splits the second operand into halves.
`default_nettype none

module ssd_prod
    import ssd_pkg::*;
#(
    parameter int AW = 37,
    parameter int BW = 37
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0]    o_p
);

    localparam int LB    = BW / 2;
    localparam int HB    = BW - LB;
    localparam int PLO_W = AW + LB + 1;
    localparam int PHI_W = AW + HB;
    localparam int PW    = AW + BW;

    logic signed [LB:0]      b_lo;
    logic signed [HB-1:0]    b_hi;
    logic signed [PLO_W-1:0] n_lo;
    logic signed [PHI_W-1:0] n_hi;
    logic signed [PLO_W-1:0] r_lo;
    logic signed [PHI_W-1:0] r_hi;
    logic signed [PW-1:0]    n_p;

    // The low half is unsigned, the high half carries the sign.
    assign b_lo = $signed({1'b0, i_b[LB-1:0]});
    assign b_hi = i_b[BW-1:LB];
    assign n_lo = PLO_W'(i_a) * PLO_W'(b_lo);
    assign n_hi = PHI_W'(i_a) * PHI_W'(b_hi);
    assign n_p  = (PW'(r_hi) <<< LB) + PW'(r_lo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            o_p  <= n_p;
        end
    end

endmodule

`default_nettype wire

>>> rtl/staggered_stencil_derivative_core.sv
// Top level of the staggered stencil derivative core.
`default_nettype none

// The core takes one beat per clock, each carrying a five-point field stencil and a
// four-point staggered velocity stencil in signed Q15.16, and returns one beat with
// the derivative selected by the method register, truncated toward zero and clamped
// to 32 bits with a flag that says whether clamping happened. It sustains one beat
// per clock while the output is not stalled. The pipeline has nine register stages:
// stencil combination, two stages of split multiplier, numerator difference,
// magnitude and scaling shift, two stages of reciprocal multiplier for the
// divide-by-three methods, remainder correction and finally the saturating output
// register. A stall on the output freezes the whole pipeline, so the input stall
// follows the output stall whenever the output holds a beat. The method register
// may only be rewritten while no beat is in flight; its write port is always
// ready. Grid-spacing scaling is left to the user.

module staggered_stencil_derivative_core
    import ssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data
);

    localparam int NSTAGE = 9;
    localparam int PQ_W   = QW + 1 + DATA_WIDTH + 1;

    localparam logic [QW-1:0] HALF_RANGE = QW'(1) << (DATA_WIDTH - 1);
    localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    t_method r_method;

    // Stage valid bits; index NSTAGE-1 is the output register.
    logic [NSTAGE-1:0] r_v;
    logic              adv;

    // Stage 1 registers.
    logic signed [OP_W-1:0] r_s1_x1, r_s1_y1, r_s1_x2, r_s1_y2;
    logic signed [OP_W-1:0] n_s1_x1, n_s1_y1, n_s1_x2, n_s1_y2;
    t_ctl                   r_s1_ctl, n_s1_ctl;

    // Side registers beside the product pipeline.
    t_ctl r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic signed [PROD_W-1:0] p1, p2;
    logic signed [PROD_W:0]   n_s4_diff;
    logic signed [NUM_W-1:0]  r_s4_n;

    logic [NUM_W-1:0] n_s5_mag;
    logic [NUM_W-1:0] r_s5_m;
    logic             r_s5_neg, r_s5_div3;

    logic [QW-1:0] r_s6_m, r_s7_m;
    logic          r_s6_hi, r_s7_hi, r_s6_neg, r_s7_neg, r_s6_div3, r_s7_div3;

    logic signed [PQ_W-1:0] pq;
    logic [DATA_WIDTH-1:0]  q0;
    logic [QW:0]            corr_r;
    logic [QW-1:0]          n_s8_q;
    logic [QW-1:0]          r_s8_q;
    logic                   r_s8_hi, r_s8_neg;

    logic over;
    t_out n_out;

    // Configuration: a single register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= M_DDX_C2;
        end else if (i_cfg_valid) begin
            r_method <= t_method'(i_cfg_data);
        end
    end

    // The pipeline moves as one; it only holds when the output beat is refused.
    assign adv         = ~r_v[NSTAGE-1] | ~i_out_stall;
    assign o_in_stall  = ~adv;
    assign o_out_valid = r_v[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NSTAGE-2:0], i_in_valid};
        end
    end

    // Stage 1: every method is brought to the form x1*y1 - x2*y2. The upwind
    // advection forms fold the velocity divergence term into the face selection,
    // and the linear methods pass through the multiplier with a unit factor.
    always_comb begin
        logic signed [OP_W-1:0] fmm, fm, fc, fp, fpp, vmm, vm, vp, vpp;
        logic signed [OP_W-1:0] dfpm, vsum;
        logic                   vp_nn, vm_nn;

        fmm   = OP_W'(i_in.f_mm);
        fm    = OP_W'(i_in.f_m);
        fc    = OP_W'(i_in.f_c);
        fp    = OP_W'(i_in.f_p);
        fpp   = OP_W'(i_in.f_pp);
        vmm   = OP_W'(i_in.v_mm);
        vm    = OP_W'(i_in.v_m);
        vp    = OP_W'(i_in.v_p);
        vpp   = OP_W'(i_in.v_pp);
        dfpm  = fp - fm;
        vsum  = vp + vm;
        // A zero velocity counts as flowing in the positive direction.
        vp_nn = ~i_in.v_p[DATA_WIDTH-1];
        vm_nn = ~i_in.v_m[DATA_WIDTH-1];

        n_s1_x1      = '0;
        n_s1_y1      = '0;
        n_s1_x2      = '0;
        n_s1_y2      = '0;
        n_s1_ctl.sh   = SH_NONE;
        n_s1_ctl.div3 = 1'b0;

        unique case (r_method)
            M_DDX_C2: begin
                n_s1_x1 = dfpm;
                n_s1_y1 = OP_W'(1);
            end
            M_DDX_C4: begin
                n_s1_x1       = dfpm;
                n_s1_y1       = OP_W'(27);
                n_s1_x2       = fpp - fmm;
                n_s1_y2       = OP_W'(1);
                n_s1_ctl.sh   = SH_C4;
                n_s1_ctl.div3 = 1'b1;
            end
            M_D2DX2_C2: begin
                n_s1_x1     = fpp + fmm - fp - fm;
                n_s1_y1     = OP_W'(1);
                n_s1_ctl.sh = SH_HALF;
            end
            M_VDDX_U1: begin
                n_s1_x1     = vp;
                n_s1_y1     = vp_nn ? '0 : fp - fc;
                n_s1_x2     = vm;
                n_s1_y2     = vm_nn ? fm - fc : '0;
                n_s1_ctl.sh = SH_PROD;
            end
            M_VDDX_U2: begin
                n_s1_x1     = vp;
                n_s1_y1     = vp_nn ? fc - fm : (fp <<< 1) + fp - fpp - (fc <<< 1);
                n_s1_x2     = vm;
                n_s1_y2     = vm_nn ? (fm <<< 1) + fm - fmm - (fc <<< 1) : fc - fp;
                n_s1_ctl.sh = SH_U2;
            end
            M_VDDX_C2: begin
                n_s1_x1     = vsum;
                n_s1_y1     = dfpm;
                n_s1_ctl.sh = SH_VC2;
            end
            M_VDDX_C4: begin
                n_s1_x1       = (vsum <<< 3) + vsum - vmm - vpp;
                n_s1_y1       = (dfpm <<< 3) + fmm - fpp;
                n_s1_ctl.sh   = SH_VC4;
                n_s1_ctl.div3 = 1'b1;
            end
            M_FDDX_U1: begin
                n_s1_x1     = vp;
                n_s1_y1     = vp_nn ? fc : fp;
                n_s1_x2     = vm;
                n_s1_y2     = vm_nn ? fm : fc;
                n_s1_ctl.sh = SH_PROD;
            end
            M_FDDX_U2: begin
                n_s1_x1     = vp;
                n_s1_y1     = vp_nn ? (fc <<< 1) + fc - fm : (fp <<< 1) + fp - fpp;
                n_s1_x2     = vm;
                n_s1_y2     = vm_nn ? (fm <<< 1) + fm - fmm : (fc <<< 1) + fc - fp;
                n_s1_ctl.sh = SH_U2;
            end
            default: begin
                // Unused codes give a zero numerator and so a zero result.
                n_s1_x1 = '0;
            end
        endcase
    end

    // Stages 2 and 3: the two products, each through a split multiplier.
    ssd_prod #(
        .AW (OP_W),
        .BW (OP_W)
    ) u_prod1 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_s1_x1),
        .i_b   (r_s1_y1),
        .o_p   (p1)
    );

    ssd_prod #(
        .AW (OP_W),
        .BW (OP_W)
    ) u_prod2 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_s1_x2),
        .i_b   (r_s1_y2),
        .o_p   (p2)
    );

    // Stage 4: numerator. Stage 5: magnitude, then the scaling shift, which
    // truncates toward zero because it works on the magnitude.
    assign n_s4_diff = (PROD_W + 1)'(p1) - (PROD_W + 1)'(p2);
    assign n_s5_mag  = r_s4_n[NUM_W-1] ? NUM_W'(-r_s4_n) : NUM_W'(r_s4_n);

    // Stages 6 and 7: quotient estimate m*K >> S, at most one below m/3.
    ssd_prod #(
        .AW (QW + 1),
        .BW (DATA_WIDTH + 1)
    ) u_recip (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   ($signed({1'b0, r_s5_m[QW-1:0]})),
        .i_b   ($signed({1'b0, RECIP_K})),
        .o_p   (pq)
    );

    // Stage 8: one correction step from the remainder, which lies in 0..5.
    assign q0     = pq[RECIP_S +: DATA_WIDTH];
    assign corr_r = (QW + 1)'(r_s7_m) - (((QW + 1)'(q0) << 1) + (QW + 1)'(q0));
    assign n_s8_q = r_s7_div3 ? QW'(q0) + QW'(corr_r >= (QW + 1)'(3)) : r_s7_m;

    // Stage 9: saturation and sign. A negative result may reach one further.
    assign over = r_s8_hi | (r_s8_neg ? (r_s8_q > HALF_RANGE) : (r_s8_q >= HALF_RANGE));

    always_comb begin
        n_out.saturated = over;
        if (over) begin
            n_out.deriv_out = r_s8_neg ? MIN_VAL : MAX_VAL;
        end else if (r_s8_neg) begin
            n_out.deriv_out = DATA_WIDTH'(-r_s8_q);
        end else begin
            n_out.deriv_out = DATA_WIDTH'(r_s8_q);
        end
    end

    // Datapath registers carry no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x1   <= n_s1_x1;
            r_s1_y1   <= n_s1_y1;
            r_s1_x2   <= n_s1_x2;
            r_s1_y2   <= n_s1_y2;
            r_s1_ctl  <= n_s1_ctl;
            r_s2_ctl  <= r_s1_ctl;
            r_s3_ctl  <= r_s2_ctl;
            r_s4_n    <= NUM_W'(n_s4_diff);
            r_s4_ctl  <= r_s3_ctl;
            r_s5_m    <= n_s5_mag >> r_s4_ctl.sh;
            r_s5_neg  <= r_s4_n[NUM_W-1];
            r_s5_div3 <= r_s4_ctl.div3;
            r_s6_m    <= r_s5_m[QW-1:0];
            r_s6_hi   <= (r_s5_m >> QW) != '0;
            r_s6_neg  <= r_s5_neg;
            r_s6_div3 <= r_s5_div3;
            r_s7_m    <= r_s6_m;
            r_s7_hi   <= r_s6_hi;
            r_s7_neg  <= r_s6_neg;
            r_s7_div3 <= r_s6_div3;
            r_s8_q    <= n_s8_q;
            r_s8_hi   <= r_s7_hi;
            r_s8_neg  <= r_s7_neg;
            o_out     <= n_out;
        end
    end

    // A clamped result is always one of the two range limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |->
            (o_out.deriv_out == MAX_VAL) || (o_out.deriv_out == MIN_VAL))
        else $error("saturated result is not a range limit");

    // A held pipeline keeps its occupancy.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v))
        else $error("pipeline occupancy changed while held");

    // An accepted beat always lands in the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_in_valid |=> r_v[0])
        else $error("accepted beat lost at pipeline entry");

    // The reciprocal estimate is never more than one below the true quotient.
    a_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] && r_s7_div3 |-> corr_r < (QW + 1)'(6))
        else $error("divide-by-three remainder out of range");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_v == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
